/* rtl/ipu_pkg.sv */
// ----------------------------------------------------------------------------
// ipu_pkg
// shared types, sizes and codes of the integer pixel upscaler
// ----------------------------------------------------------------------------
package ipu_pkg;

	// line store depth and largest enlargement factor
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_FACTOR = 100;

	// pixel counter holds 0..MAX_WIDTH, store index holds 0..MAX_WIDTH-1
	localparam int CNT_W = $clog2(MAX_WIDTH + 1);
	localparam int IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	// register field widths
	localparam int FAC_W      = 7;
	localparam int SRCW_W     = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b1;

	// request functions
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_PULL = 1'b1;

	typedef struct packed {
		logic       func;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} req_t;

	typedef struct packed {
		logic       valid_res;
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic       line_end;
		logic [1:0] pad_bytes;
		logic       row_done;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_px;
		logic pull;
		logic out_load;
	} cmd_t;

endpackage

/* rtl/ipu_ctrl.sv */
// ----------------------------------------------------------------------------
// ipu_ctrl
// request sequencing and output register handshake
// ----------------------------------------------------------------------------
module ipu_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  logic          req_func,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ipu_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd.load_px  = accept && (req_func == ipu_pkg::FUNC_LOAD);
		cmd.pull     = accept && (req_func == ipu_pkg::FUNC_PULL);
		cmd.out_load = (state_q == S_READ) && out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.pull) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				// wait here until the output register can take the word
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/ipu_dpath.sv */
// ----------------------------------------------------------------------------
// ipu_dpath
// line store, scan counters, registers and output word
// ----------------------------------------------------------------------------
module ipu_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ipu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ipu_pkg::CFG_DATA_W-1:0] cfg_data,
	input  ipu_pkg::req_t                  req,
	input  ipu_pkg::cmd_t                  cmd,
	output ipu_pkg::rsp_t                  rsp
);

	logic [ipu_pkg::FAC_W-1:0]  scale_q;
	logic [ipu_pkg::SRCW_W-1:0] width_q;

	logic [ipu_pkg::CNT_W-1:0] load_count_q;
	logic [ipu_pkg::IDX_W-1:0] read_index_q;
	logic [ipu_pkg::FAC_W-1:0] hrep_q;
	logic [ipu_pkg::FAC_W-1:0] vcopy_q;

	logic [ipu_pkg::CNT_W-1:0] w_eff;
	logic [ipu_pkg::FAC_W-1:0] f_eff;
	logic [ipu_pkg::CNT_W-1:0] rd_ext;
	logic [ipu_pkg::CNT_W-1:0] idx_c;
	logic                      full;
	logic                      last_rep;
	logic                      last_px;
	logic                      last_copy;
	logic [1:0]                w_lo;
	logic [1:0]                f_lo;
	logic [3:0]                wf_lo;

	logic [23:0] store_mem [ipu_pkg::MAX_WIDTH];
	logic [23:0] rdata_s1;
	logic        valid_s1;
	logic        line_end_s1;
	logic [1:0]  pad_s1;
	logic        row_done_s1;

	// clamp registers to their working ranges
	always_comb begin
		if (width_q == '0) begin
			w_eff = ipu_pkg::CNT_W'(1);
		end else if (int'(width_q) > ipu_pkg::MAX_WIDTH) begin
			w_eff = ipu_pkg::CNT_W'(ipu_pkg::MAX_WIDTH);
		end else begin
			w_eff = ipu_pkg::CNT_W'(width_q);
		end
		if (scale_q == '0) begin
			f_eff = ipu_pkg::FAC_W'(1);
		end else if (int'(scale_q) > ipu_pkg::MAX_FACTOR) begin
			f_eff = ipu_pkg::FAC_W'(ipu_pkg::MAX_FACTOR);
		end else begin
			f_eff = scale_q;
		end
	end

	assign full   = (load_count_q >= w_eff);
	assign rd_ext = ipu_pkg::CNT_W'(read_index_q);
	assign idx_c  = (rd_ext >= w_eff) ? (w_eff - ipu_pkg::CNT_W'(1)) : rd_ext;

	assign last_rep  = (({1'b0, hrep_q} + 1'b1) >= {1'b0, f_eff});
	assign last_px   = last_rep && ((idx_c + ipu_pkg::CNT_W'(1)) >= w_eff);
	assign last_copy = last_px && (({1'b0, vcopy_q} + 1'b1) >= {1'b0, f_eff});

	// padding to a multiple of four bytes reduces to (w * f) mod 4
	assign w_lo  = 2'(w_eff);
	assign f_lo  = 2'(f_eff);
	assign wf_lo = {2'b00, w_lo} * {2'b00, f_lo};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= ipu_pkg::FAC_W'(1);
			width_q <= ipu_pkg::SRCW_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				ipu_pkg::REG_SCALE: scale_q <= cfg_data[ipu_pkg::FAC_W-1:0];
				ipu_pkg::REG_WIDTH: width_q <= cfg_data[ipu_pkg::SRCW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
			read_index_q <= '0;
			hrep_q       <= '0;
			vcopy_q      <= '0;
		end else begin
			if (cmd.load_px && !full) begin
				load_count_q <= load_count_q + ipu_pkg::CNT_W'(1);
			end
			if (cmd.pull && full) begin
				if (last_copy) begin
					load_count_q <= '0;
					read_index_q <= '0;
					hrep_q       <= '0;
					vcopy_q      <= '0;
				end else if (last_px) begin
					read_index_q <= '0;
					hrep_q       <= '0;
					vcopy_q      <= vcopy_q + 1'b1;
				end else if (last_rep) begin
					read_index_q <= idx_c[ipu_pkg::IDX_W-1:0] + 1'b1;
					hrep_q       <= '0;
				end else begin
					read_index_q <= idx_c[ipu_pkg::IDX_W-1:0];
					hrep_q       <= hrep_q + 1'b1;
				end
			end
		end
	end

	// line store, registered read
	always_ff @(posedge clk) begin
		if (cmd.load_px && !full) begin
			store_mem[load_count_q[ipu_pkg::IDX_W-1:0]] <= {req.red, req.green, req.blue};
		end
		if (cmd.pull) begin
			rdata_s1 <= store_mem[idx_c[ipu_pkg::IDX_W-1:0]];
		end
	end

	// result flags are registered together with the read data
	always_ff @(posedge clk) begin
		if (cmd.pull) begin
			valid_s1    <= full;
			line_end_s1 <= full && last_px;
			pad_s1      <= (full && last_px) ? wf_lo[1:0] : 2'b00;
			row_done_s1 <= full && last_copy;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp.valid_res <= valid_s1;
			rsp.out_blue  <= valid_s1 ? rdata_s1[7:0]   : 8'h00;
			rsp.out_green <= valid_s1 ? rdata_s1[15:8]  : 8'h00;
			rsp.out_red   <= valid_s1 ? rdata_s1[23:16] : 8'h00;
			rsp.line_end  <= line_end_s1;
			rsp.pad_bytes <= pad_s1;
			rsp.row_done  <= row_done_s1;
		end
	end

endmodule

/* rtl/integer_pixel_upscaler_unit.sv */
// ----------------------------------------------------------------------------
// integer_pixel_upscaler_unit
// nearest-neighbor integer upscaler for rows of 24-bit pixels
// ----------------------------------------------------------------------------
// usage
//   req channel: one word per request; func load stores a source pixel into
//   the line store, func pull asks for the next output pixel. loads take no
//   result word; a load while a full row is pending is dropped.
//   rsp channel: one word per pull. valid_res low means no full row is
//   stored yet. line_end and pad_bytes mark the end of each output line,
//   row_done marks the last pixel of the last copy, after which the store
//   takes the next row.
//   cfg channel: always ready; index 0 scale_factor, index 1 source_width,
//   other indexes are ignored. write only while the block is idle.
// timing
//   a load is accepted every cycle unless a pull waits in the read state. a
//   pull reads the line store through its registered read port, then the word
//   moves to the output register; no request is taken until it does.
// reset
//   counters clear, scale_factor and source_width return to 1, line store
//   contents are undefined until loaded. no clearing pass is needed.
// stall
//   the rsp word holds in the output register while rsp_ready is low; a pull
//   behind it waits in the read state and req_ready drops until it moves.
// ----------------------------------------------------------------------------
module integer_pixel_upscaler_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// request words
	input  logic                           req_valid,
	output logic                           req_ready,
	input  ipu_pkg::req_t                  req,
	// result words
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output ipu_pkg::rsp_t                  rsp,
	// register writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ipu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ipu_pkg::CFG_DATA_W-1:0] cfg_data
);

	ipu_pkg::cmd_t cmd;
	logic          cfg_we;

	// registers take a write in any cycle
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// sequencing and output handshake
	ipu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_func  (req.func),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	// line store, counters and output word
	ipu_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.rsp       (rsp)
	);

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the integer pixel upscaler: a clocked driver feeds
// load and pull words from a backlog, a clocked monitor predicts every
// result word and checks it field by field, register writes go in between
// phases while nothing is in flight
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// request channel, driven on the falling edge
	logic          req_valid = 1'b0;
	logic          req_ready;
	ipu_pkg::req_t req       = '0;

	// result channel
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	ipu_pkg::rsp_t rsp;

	// register write channel
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [ipu_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [ipu_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	integer_pixel_upscaler_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// predictor state: its own copy of the line store, counters and registers
	// ------------------------------------------------------------------------
	logic [23:0]                row_buf [ipu_pkg::MAX_WIDTH];
	int unsigned                px_loaded  = 0;
	int unsigned                src_pos    = 0;
	int unsigned                rep_cnt    = 0;
	int unsigned                copy_cnt   = 0;
	logic [ipu_pkg::FAC_W-1:0]  cfg_factor = 7'd1;
	logic [ipu_pkg::SRCW_W-1:0] cfg_width  = 11'd1;

	// result words still owed by the block, oldest first
	ipu_pkg::rsp_t exp_pixels [$];
	// request words waiting for the driver
	ipu_pkg::req_t req_backlog [$];

	int unsigned mismatches    = 0;
	int unsigned words_planned = 0;

	// handshake flags, set on the rising edge, read on the falling edge
	bit req_taken  = 1'b0;
	bit rsp_taken  = 1'b0;
	// phase controls from the sequencer
	bit quiet      = 1'b0;
	bit long_stall = 1'b0;

	int unsigned req_gap    = 0;
	int unsigned rsp_gap    = 0;
	int unsigned stall_left = 0;

	// zero and out-of-range registers fold into the legal range
	function automatic int unsigned width_eff();
		int unsigned v;
		v = cfg_width;
		if (v == 0) v = 1;
		if (v > ipu_pkg::MAX_WIDTH) v = ipu_pkg::MAX_WIDTH;
		return v;
	endfunction

	function automatic int unsigned factor_eff();
		int unsigned v;
		v = cfg_factor;
		if (v == 0) v = 1;
		if (v > ipu_pkg::MAX_FACTOR) v = ipu_pkg::MAX_FACTOR;
		return v;
	endfunction

	// cycles a side waits before its next word
	function automatic int unsigned draw_wait();
		return quiet ? 0 : $urandom_range(0, 18);
	endfunction

	// random byte with the all-zero and all-one values made common
	function automatic logic [7:0] rand_byte();
		int unsigned pick;
		pick = $urandom_range(0, 7);
		if (pick == 0) return 8'h00;
		if (pick == 1) return 8'hff;
		return 8'($urandom_range(0, 255));
	endfunction

	// advance the upscaler copy by one accepted request word
	task automatic upscale_predict(input ipu_pkg::req_t word);
		int unsigned   w, f, idx, nbytes;
		logic [23:0]   px;
		bit            full, last_rep, last_px, last_copy;
		ipu_pkg::rsp_t want;
		w    = width_eff();
		f    = factor_eff();
		full = (px_loaded >= w);
		if (word.func == ipu_pkg::FUNC_LOAD) begin
			// loads while a row is pending are dropped
			if (!full) begin
				if (px_loaded < ipu_pkg::MAX_WIDTH)
					row_buf[ipu_pkg::IDX_W'(px_loaded)] = {word.red, word.green, word.blue};
				px_loaded++;
			end
		end else begin
			want = '0;
			if (full) begin
				// a smaller width can leave the index past the row end
				idx = (src_pos >= w) ? w - 1 : src_pos;
				px  = row_buf[ipu_pkg::IDX_W'(idx)];
				want.valid_res = 1'b1;
				want.out_blue  = px[7:0];
				want.out_green = px[15:8];
				want.out_red   = px[23:16];
				// at-or-beyond compares end a repeat, line or row at once
				last_rep  = (rep_cnt + 1 >= f);
				last_px   = last_rep && (idx + 1 >= w);
				last_copy = last_px && (copy_cnt + 1 >= f);
				if (last_px) begin
					nbytes         = w * f * 3;
					want.line_end  = 1'b1;
					want.pad_bytes = 2'((4 - (nbytes & 3)) & 3);
				end
				if (last_copy) begin
					want.row_done = 1'b1;
					px_loaded = 0;
					src_pos   = 0;
					rep_cnt   = 0;
					copy_cnt  = 0;
				end else if (last_px) begin
					src_pos = 0;
					rep_cnt = 0;
					copy_cnt++;
				end else if (last_rep) begin
					src_pos = idx + 1;
					rep_cnt = 0;
				end else begin
					src_pos = idx;
					rep_cnt++;
				end
			end
			exp_pixels.push_back(want);
		end
	endtask

	task automatic note_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// ------------------------------------------------------------------------
	// driver: one request word at a time, gap drawn after each accepted word
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (req_valid && !req_taken) begin
			// word still offered, hold it
		end else begin
			if (req_valid) req_gap = draw_wait();
			if (req_gap > 0) begin
				req_gap--;
				req_valid <= 1'b0;
			end else if (req_backlog.size() > 0) begin
				req       <= req_backlog.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// receiver: random wait after each result word, plus one long hold-off
	// counted here while the sender keeps going
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (rsp_taken) rsp_gap = draw_wait();
		if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else if (long_stall) begin
			long_stall = 1'b0;
			stall_left = 400;
			rsp_ready  <= 1'b0;
		end else if (rsp_gap > 0) begin
			rsp_gap--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// monitor: check result words against the oldest expectation, then
	// predict for any request word taken on this edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		ipu_pkg::rsp_t want;
		req_taken = 1'b0;
		rsp_taken = 1'b0;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				rsp_taken = 1'b1;
				if (exp_pixels.size() == 0) begin
					note_mismatch("unexpected word", 1, 0);
				end else begin
					want = exp_pixels.pop_front();
					if (rsp.valid_res !== want.valid_res)
						note_mismatch("valid_res", rsp.valid_res, want.valid_res);
					if (rsp.out_blue !== want.out_blue)
						note_mismatch("out_blue", rsp.out_blue, want.out_blue);
					if (rsp.out_green !== want.out_green)
						note_mismatch("out_green", rsp.out_green, want.out_green);
					if (rsp.out_red !== want.out_red)
						note_mismatch("out_red", rsp.out_red, want.out_red);
					if (rsp.line_end !== want.line_end)
						note_mismatch("line_end", rsp.line_end, want.line_end);
					if (rsp.pad_bytes !== want.pad_bytes)
						note_mismatch("pad_bytes", rsp.pad_bytes, want.pad_bytes);
					if (rsp.row_done !== want.row_done)
						note_mismatch("row_done", rsp.row_done, want.row_done);
				end
			end
			if (req_valid && req_ready) begin
				req_taken = 1'b1;
				upscale_predict(req);
			end
		end
	end

	// ------------------------------------------------------------------------
	// sequencing helpers
	// ------------------------------------------------------------------------
	task automatic push_word(input logic func, input logic [7:0] b, input logic [7:0] g,
			input logic [7:0] r);
		ipu_pkg::req_t word;
		word.func  = func;
		word.blue  = b;
		word.green = g;
		word.red   = r;
		req_backlog.push_back(word);
	endtask

	// block idle: backlog sent, nothing owed, loads given time to land
	task automatic wait_idle();
		do @(posedge clk);
		while (req_backlog.size() != 0 || req_valid || exp_pixels.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [ipu_pkg::CFG_IDX_W-1:0] idx,
			input logic [ipu_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk);
		while (!cfg_ready);
		case (idx)
			ipu_pkg::REG_SCALE: cfg_factor = data[ipu_pkg::FAC_W-1:0];
			ipu_pkg::REG_WIDTH: cfg_width  = data[ipu_pkg::SRCW_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// finish loading the current row, then pull up to pull_cap pixels of it;
	// noisy mixes in early pulls and loads that land on a pending row
	task automatic plan_row(input int unsigned pull_cap, input bit noisy);
		int unsigned w, f, left, done_px, n, i;
		w = width_eff();
		f = factor_eff();
		for (i = px_loaded; i < w; i++) begin
			if (noisy && $urandom_range(0, 7) == 0)
				push_word(ipu_pkg::FUNC_PULL, rand_byte(), rand_byte(), rand_byte());
			push_word(ipu_pkg::FUNC_LOAD, rand_byte(), rand_byte(), rand_byte());
			words_planned++;
		end
		left = w * f * f;
		if (px_loaded >= w) begin
			done_px = copy_cnt * w * f + src_pos * f + rep_cnt;
			left    = (done_px < left) ? left - done_px : 1;
		end
		n = (left < pull_cap) ? left : pull_cap;
		for (i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 7) == 0)
				push_word(ipu_pkg::FUNC_LOAD, rand_byte(), rand_byte(), rand_byte());
			push_word(ipu_pkg::FUNC_PULL, rand_byte(), rand_byte(), rand_byte());
			words_planned++;
		end
	endtask

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin : sequencer
		int unsigned phase, pick, sel;
		logic [ipu_pkg::CFG_DATA_W-1:0] fac_data, wid_data;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// pull before any row is stored
		push_word(ipu_pkg::FUNC_PULL, 8'hff, 8'hff, 8'hff);
		wait_idle();

		// zero registers act as one; second load hits a pending row
		cfg_write(ipu_pkg::REG_SCALE, '0);
		cfg_write(ipu_pkg::REG_WIDTH, '0);
		push_word(ipu_pkg::FUNC_LOAD, 8'hff, 8'hff, 8'hff);
		push_word(ipu_pkg::FUNC_LOAD, 8'h00, 8'h00, 8'h00);
		push_word(ipu_pkg::FUNC_PULL, 8'h00, 8'h00, 8'h00);
		wait_idle();

		// three pixels doubled both ways
		cfg_write(ipu_pkg::REG_SCALE, 11'd2);
		cfg_write(ipu_pkg::REG_WIDTH, 11'd3);
		push_word(ipu_pkg::FUNC_LOAD, 8'h00, 8'h00, 8'h00);
		push_word(ipu_pkg::FUNC_LOAD, 8'hff, 8'h00, 8'hff);
		push_word(ipu_pkg::FUNC_LOAD, 8'h5a, 8'hff, 8'ha5);
		repeat (12) push_word(ipu_pkg::FUNC_PULL, 8'h00, 8'hff, 8'h00);
		wait_idle();

		// all-ones data: factor saturates, width saturates so the row is short
		cfg_write(ipu_pkg::REG_SCALE, 11'h7ff);
		cfg_write(ipu_pkg::REG_WIDTH, 11'h7ff);
		push_word(ipu_pkg::FUNC_LOAD, 8'h12, 8'h34, 8'h56);
		push_word(ipu_pkg::FUNC_LOAD, 8'hed, 8'hcb, 8'ha9);
		push_word(ipu_pkg::FUNC_PULL, 8'hff, 8'h00, 8'hff);
		wait_idle();

		// width drops to the stored count mid-row, row becomes pending
		cfg_write(ipu_pkg::REG_WIDTH, 11'd2);
		repeat (3) push_word(ipu_pkg::FUNC_PULL, 8'h00, 8'h00, 8'h00);
		wait_idle();

		// factor drops under the repeat counter, repeat ends at once
		cfg_write(ipu_pkg::REG_SCALE, 11'd1);
		repeat (3) push_word(ipu_pkg::FUNC_PULL, 8'hff, 8'hff, 8'hff);
		wait_idle();

		// random phases, each starting from an idle block
		phase         = 0;
		words_planned = 0;
		while (words_planned < 1900) begin
			quiet = ($urandom_range(0, 3) == 0);
			if (phase == 2) begin
				// receiver holds off long while the sender keeps offering
				quiet      = 1'b1;
				long_stall = 1'b1;
				cfg_write(ipu_pkg::REG_SCALE, 11'd3);
				cfg_write(ipu_pkg::REG_WIDTH, 11'd4);
				plan_row(160, 1'b0);
			end else if (phase == 6) begin
				// one full-depth row, only its head pulled
				quiet = 1'b1;
				cfg_write(ipu_pkg::REG_SCALE, 11'd1);
				cfg_write(ipu_pkg::REG_WIDTH, 11'd1024);
				plan_row(64, 1'b0);
			end else begin
				if (phase == 0 || $urandom_range(0, 1) == 1) begin
					pick = $urandom_range(0, 9);
					case (pick)
						0:       fac_data = 11'd0;
						1:       fac_data = 11'd127;
						2:       fac_data = 11'd100;
						3:       fac_data = 11'($urandom_range(6, 127));
						default: fac_data = 11'($urandom_range(1, 4));
					endcase
					// bits above the factor field are dropped by the block
					fac_data[ipu_pkg::CFG_DATA_W-1:ipu_pkg::FAC_W] = 4'($urandom_range(0, 15));
					pick = $urandom_range(0, 9);
					case (pick)
						0:       wid_data = 11'd0;
						1:       wid_data = 11'd1;
						2:       wid_data = 11'($urandom_range(11, 60));
						default: wid_data = 11'($urandom_range(2, 10));
					endcase
					sel = $urandom_range(1, 3);
					if (sel[0]) cfg_write(ipu_pkg::REG_SCALE, fac_data);
					if (sel[1]) cfg_write(ipu_pkg::REG_WIDTH, wid_data);
				end
				// some rows are cut short so the next write lands mid-row
				if ($urandom_range(0, 3) == 0) plan_row($urandom_range(1, 20), 1'b1);
				else plan_row(160, 1'b1);
			end
			wait_idle();
			phase++;
		end

		// idle tail to catch stray words
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// hang guard
	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
